>>> hdl/evfm_pkg.sv
package evfm_pkg;

    localparam int unsigned VAR_W      = 16;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned INTERVAL_W = 20;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VARIANCE_THRESHOLD = 2'd0,
        CFG_FAILSAFE_ACTION    = 2'd1,
        CFG_FAIL_LIMIT         = 2'd2,
        CFG_WARN_INTERVAL_MS   = 2'd3
    } t_cfg_idx;

    localparam logic [VAR_W-1:0]      RST_VARIANCE_THRESHOLD = 16'd205;
    localparam logic                  RST_FAILSAFE_ACTION    = 1'b1;
    localparam logic [COUNT_W-1:0]    RST_FAIL_LIMIT         = 8'd10;
    localparam logic [INTERVAL_W-1:0] RST_WARN_INTERVAL_MS   = 20'd30000;
    localparam logic [COUNT_W-1:0]    COUNT_MAX              = '1;
    localparam logic                  ACTION_HOLD            = 1'b1;

    typedef struct packed {
        logic              origin_set;
        logic              armed;
        logic [VAR_W-1:0]  mag_var_len;
        logic [VAR_W-1:0]  vel_var;
        logic [VAR_W-1:0]  pos_var;
        logic              inertial_nav;
        logic              abs_hpos_good;
        logic              fixed_pos_mode;
        logic              needs_position;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic variance_bad;
        logic failsafe_active;
        logic went_bad;
        logic went_good;
        logic failsafe_set;
        logic failsafe_clear;
        logic request_hold;
        logic send_warning;
    } t_out_word;

endpackage

>>> hdl/evfm_if.sv
interface evfm_in_if;
    import evfm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface evfm_out_if;
    import evfm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface evfm_cfg_if;
    import evfm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/ekf_variance_failsafe_monitor.sv
// Estimator variance failsafe monitor.
// i_in carries one estimator check per word: origin/armed/position flags,
// three Q8.8 variances, the drive-mode flag and a wrapping ms time.
// o_out returns one result word per check: bad flag, failsafe latch and
// the event bits (went bad/good, failsafe set/clear, hold request, warning).
// i_cfg writes the four registers by index (threshold, action, fail limit,
// warning interval); it is always ready. The user must write it only while
// idle; the block does not enforce this. One input register holds a check,
// then the compare/count logic updates the state and the result register.
// One check is accepted per cycle while o_out is not stalled; the count
// and latch state are read and written by that single stage.
// When o_out is stalled the result register holds, the input register
// fills, and then i_in.ready drops until the result is taken.
// Synchronous active-low reset clears both valids, the counter, the bad
// flag, the latch and the last warning time, and loads register defaults.
module ekf_variance_failsafe_monitor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    evfm_in_if.sink              i_in,
    evfm_out_if.source           o_out,
    evfm_cfg_if.sink             i_cfg
);
    import evfm_pkg::*;

    logic [VAR_W-1:0]      r_threshold;
    logic                  r_action;
    logic [COUNT_W-1:0]    r_fail_limit;
    logic [INTERVAL_W-1:0] r_warn_interval;

    logic                  r_in_vld;
    t_in_word              r_in;
    logic                  r_out_vld;
    t_out_word             r_out;

    logic [COUNT_W-1:0]    r_bad_count, n_bad_count;
    logic                  r_bad_flag, n_bad_flag;
    logic                  r_fs_latch, n_fs_latch;
    logic [TIME_W-1:0]     r_last_warn, n_last_warn;
    t_out_word             n_out;

    logic                  adv;
    logic                  mag_over, vel_over, pos_over;
    logic                  bad_tick;
    logic [COUNT_W-1:0]    cnt_inc;
    logic [TIME_W-1:0]     warn_age;

    assign adv        = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_in_vld || adv;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= RST_VARIANCE_THRESHOLD;
            r_action        <= RST_FAILSAFE_ACTION;
            r_fail_limit    <= RST_FAIL_LIMIT;
            r_warn_interval <= RST_WARN_INTERVAL_MS;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_VARIANCE_THRESHOLD: r_threshold     <= i_cfg.data[VAR_W-1:0];
                CFG_FAILSAFE_ACTION:    r_action        <= i_cfg.data[0];
                CFG_FAIL_LIMIT:         r_fail_limit    <= i_cfg.data[COUNT_W-1:0];
                CFG_WARN_INTERVAL_MS:   r_warn_interval <= i_cfg.data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    assign mag_over = r_in.mag_var_len >= r_threshold;
    assign vel_over = r_in.vel_var >= r_threshold;
    assign pos_over = r_in.pos_var >= r_threshold;
    assign bad_tick = (mag_over && vel_over) || (mag_over && pos_over) ||
                      (vel_over && pos_over) ||
                      !(r_in.inertial_nav && r_in.abs_hpos_good && !r_in.fixed_pos_mode);
    assign cnt_inc  = (r_bad_count == COUNT_MAX) ? COUNT_MAX : r_bad_count + 1'b1;
    assign warn_age = r_in.now_ms - r_last_warn;

    always_comb begin
        n_bad_count = r_bad_count;
        n_bad_flag  = r_bad_flag;
        n_fs_latch  = r_fs_latch;
        n_last_warn = r_last_warn;
        n_out       = '0;
        if (r_in.origin_set) begin
            if (!r_in.armed || r_threshold == '0) begin
                n_out.went_good      = r_bad_flag;
                n_out.failsafe_clear = r_fs_latch;
                n_bad_count          = '0;
                n_bad_flag           = 1'b0;
                n_fs_latch           = 1'b0;
            end else if (bad_tick) begin
                if (!r_bad_flag) begin
                    n_bad_count = cnt_inc;
                    if (cnt_inc >= r_fail_limit) begin
                        n_bad_count    = r_fail_limit;
                        n_bad_flag     = 1'b1;
                        n_out.went_bad = 1'b1;
                        if (warn_age > TIME_W'(r_warn_interval)) begin
                            n_out.send_warning = 1'b1;
                            n_last_warn        = r_in.now_ms;
                        end
                        if (!r_fs_latch) begin
                            n_fs_latch         = 1'b1;
                            n_out.failsafe_set = 1'b1;
                            n_out.request_hold = r_in.needs_position &&
                                                 (r_action == ACTION_HOLD);
                        end
                    end
                end
            end else if (r_bad_count != '0) begin
                n_bad_count = r_bad_count - 1'b1;
                if (r_bad_flag && r_bad_count == COUNT_W'(1)) begin
                    n_bad_flag           = 1'b0;
                    n_out.went_good      = 1'b1;
                    n_out.failsafe_clear = r_fs_latch;
                    n_fs_latch           = 1'b0;
                end
            end
        end
        n_out.variance_bad    = n_bad_flag;
        n_out.failsafe_active = n_fs_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_bad_count <= '0;
            r_bad_flag  <= 1'b0;
            r_fs_latch  <= 1'b0;
            r_last_warn <= '0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_bad_count <= n_bad_count;
                r_bad_flag  <= n_bad_flag;
                r_fs_latch  <= n_fs_latch;
                r_last_warn <= n_last_warn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    a_latch_tracks_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fs_latch == r_bad_flag)
        else $error("failsafe latch and bad flag disagree");

    a_no_origin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_vld && !r_in.origin_set) |=>
            ($stable(r_bad_count) && $stable(r_bad_flag) && $stable(r_last_warn)))
        else $error("state changed on a check without origin");

    a_events_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.went_bad && r_out.went_good))
        else $error("went bad and went good in one word");

    a_hold_needs_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.request_hold) |-> r_out.failsafe_set)
        else $error("hold requested without failsafe set");

    a_warn_needs_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.send_warning) |-> r_out.went_bad)
        else $error("warning sent without going bad");

endmodule
